@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising clock, off while reset is high
`define BSLP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bslp check failed");

// concurrent check on the rising clock, also active during reset
`define BSLP_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("bslp check failed");

`endif

@@ rtl/bslp_pkg.sv @@
`timescale 1ns / 1ps

package bslp_pkg;

   localparam int unsigned PERIOD_W = 10;
   localparam int unsigned HOLD_W   = 16;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [PERIOD_W-1:0] SAMPLE_PERIOD_RESET = 10'd50;
   localparam logic [HOLD_W-1:0]   LONG_PRESS_RESET    = 16'd1000;
   localparam logic [HOLD_W-1:0]   HOLD_MAX            = 16'hFFFF;

   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_PERIOD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS    = 2'd1;

   typedef struct packed {
      logic short_ev;
      logic long_ev;
   } bslp_event_type;

   typedef struct packed {
      bslp_event_type next_ev;
      bslp_event_type select_ev;
      logic           next_active;
      logic           select_active;
   } bslp_result_type;

endpackage

@@ rtl/bslp_sampler.sv @@
`timescale 1ns / 1ps

module bslp_sampler
   import bslp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic [PERIOD_W-1:0] sample_period,
   output logic                sample_tick
);

   logic [PERIOD_W-1:0] countdown_ff;
   logic [PERIOD_W-1:0] countdown_in;

   assign sample_tick = (countdown_ff <= PERIOD_W'(1));

   always_comb begin
      countdown_in = countdown_ff;
      if (advance) begin
         if (sample_tick) begin
            countdown_in = sample_period;
         end else begin
            countdown_in = countdown_ff - PERIOD_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         countdown_ff <= SAMPLE_PERIOD_RESET;
      end else begin
         countdown_ff <= countdown_in;
      end
   end

endmodule

@@ rtl/bslp_lane.sv @@
`timescale 1ns / 1ps

module bslp_lane
   import bslp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              sample_tick,
   input  logic              pressed,
   input  logic [HOLD_W-1:0] long_press_time,
   output bslp_event_type    events
);

   logic              held_ff;
   logic              held_in;
   logic              repeat_ff;
   logic              repeat_in;
   logic [HOLD_W-1:0] timer_ff;
   logic [HOLD_W-1:0] timer_in;
   logic [HOLD_W-1:0] timer_inc;

   // advance the hold timer first, saturating
   assign timer_inc = (held_ff && (timer_ff != HOLD_MAX)) ? timer_ff + HOLD_W'(1) : timer_ff;

   always_comb begin
      held_in         = held_ff;
      repeat_in       = repeat_ff;
      timer_in        = timer_ff;
      events.short_ev = 1'b0;
      events.long_ev  = 1'b0;
      if (advance) begin
         timer_in = timer_inc;
         if (sample_tick) begin
            if (pressed) begin
               if (held_ff) begin
                  if (timer_inc > long_press_time) begin
                     events.long_ev = 1'b1;
                     repeat_in      = 1'b1;
                     timer_in       = '0;
                  end
               end else begin
                  held_in  = 1'b1;
                  timer_in = '0;
               end
            end else if (held_ff) begin
               if (repeat_ff) begin
                  repeat_in = 1'b0;
               end else begin
                  events.short_ev = 1'b1;
               end
               held_in  = 1'b0;
               timer_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff   <= 1'b0;
         repeat_ff <= 1'b0;
         timer_ff  <= '0;
      end else begin
         held_ff   <= held_in;
         repeat_ff <= repeat_in;
         timer_ff  <= timer_in;
      end
   end

endmodule

@@ rtl/button_short_long_press_detector.sv @@
`timescale 1ns / 1ps

// channel  direction  handshake              payload
// req      in         req_valid / req_stall  req_next_level, req_select_level
// rsp      out        rsp_valid / rsp_stall  six event and level bits
// csr      in         csr_valid / csr_ready  csr_index, csr_data
//
// One tick beat is taken per clock while req_stall is low; both button lanes
// and the sample countdown update in the accept cycle; the result is registered.
// A two-entry output buffer keeps req open while one result waits on rsp.
// Synchronous reset clears all lanes and the buffer and reloads the countdown.
// req_stall rises only when both output entries are full.

module button_short_long_press_detector
   import bslp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_next_level,
   input  logic                  req_select_level,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_next_short,
   output logic                  rsp_next_long,
   output logic                  rsp_select_short,
   output logic                  rsp_select_long,
   output logic                  rsp_next_active,
   output logic                  rsp_select_active,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic [PERIOD_W-1:0] period_ff;
   logic [HOLD_W-1:0]   long_time_ff;
   logic                advance;
   logic                take;
   logic                sample_tick;
   logic                next_pressed;
   logic                select_pressed;
   bslp_event_type      next_events;
   bslp_event_type      select_events;
   bslp_result_type     result;

   bslp_result_type     head_ff;
   bslp_result_type     head_in;
   logic                head_valid_ff;
   logic                head_valid_in;
   bslp_result_type     skid_ff;
   bslp_result_type     skid_in;
   logic                skid_valid_ff;
   logic                skid_valid_in;

   assign csr_ready      = 1'b1;
   assign req_stall      = skid_valid_ff;
   assign advance        = req_valid && !req_stall;
   assign take           = head_valid_ff && !rsp_stall;
   assign next_pressed   = !req_next_level;
   assign select_pressed = !req_select_level;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= SAMPLE_PERIOD_RESET;
         long_time_ff <= LONG_PRESS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SAMPLE_PERIOD: period_ff    <= csr_data[PERIOD_W-1:0];
            CSR_LONG_PRESS:    long_time_ff <= csr_data[HOLD_W-1:0];
            default: ;
         endcase
      end
   end

   bslp_sampler u_sampler (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .sample_period (period_ff),
      .sample_tick   (sample_tick)
   );

   bslp_lane u_next_lane (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .sample_tick     (sample_tick),
      .pressed         (next_pressed),
      .long_press_time (long_time_ff),
      .events          (next_events)
   );

   bslp_lane u_select_lane (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .sample_tick     (sample_tick),
      .pressed         (select_pressed),
      .long_press_time (long_time_ff),
      .events          (select_events)
   );

   // merge the lanes into one result beat
   always_comb begin
      result.next_ev       = next_events;
      result.select_ev     = select_events;
      result.next_active   = next_pressed;
      result.select_active = select_pressed;
   end

   always_comb begin
      head_in       = head_ff;
      head_valid_in = head_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (take) begin
            head_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (head_valid_ff) begin
         if (advance && take) begin
            head_in = result;
         end else if (take) begin
            head_valid_in = 1'b0;
         end else if (advance) begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else if (advance) begin
         head_in       = result;
         head_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid         = head_valid_ff;
   assign rsp_next_short    = head_ff.next_ev.short_ev;
   assign rsp_next_long     = head_ff.next_ev.long_ev;
   assign rsp_select_short  = head_ff.select_ev.short_ev;
   assign rsp_select_long   = head_ff.select_ev.long_ev;
   assign rsp_next_active   = head_ff.next_active;
   assign rsp_select_active = head_ff.select_active;

endmodule

@@ rtl/bslp_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bslp_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_next_short,
   input logic rsp_next_long,
   input logic rsp_select_short,
   input logic rsp_select_long,
   input logic rsp_next_active,
   input logic rsp_select_active
);

   logic [5:0] rsp_bits;
   logic       next_short_ok;
   logic       select_short_ok;
   logic       next_long_ok;
   logic       select_long_ok;

   assign rsp_bits = {rsp_next_short, rsp_next_long, rsp_select_short,
                      rsp_select_long, rsp_next_active, rsp_select_active};

   assign next_short_ok   = !rsp_next_active && !rsp_next_long;
   assign select_short_ok = !rsp_select_active && !rsp_select_long;
   assign next_long_ok    = !rsp_next_long || rsp_next_active;
   assign select_long_ok  = !rsp_select_long || rsp_select_active;

   `BSLP_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_bits))
   `BSLP_ASSERT(a_next_short_released, clock, reset, rsp_valid && rsp_next_short |-> next_short_ok)
   `BSLP_ASSERT(a_select_short_released, clock, reset, rsp_valid && rsp_select_short |-> select_short_ok)
   `BSLP_ASSERT_ALWAYS(a_long_while_pressed, clock, rsp_valid |-> next_long_ok && select_long_ok)

endmodule

bind button_short_long_press_detector bslp_checker u_bslp_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_next_short    (rsp_next_short),
   .rsp_next_long     (rsp_next_long),
   .rsp_select_short  (rsp_select_short),
   .rsp_select_long   (rsp_select_long),
   .rsp_next_active   (rsp_next_active),
   .rsp_select_active (rsp_select_active)
);

@@ test/button_short_long_press_detector_tb.sv @@
`timescale 1ns / 1ps

module button_short_long_press_detector_tb
   import bslp_pkg::*;
();

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;
   localparam int RANDOM_PHASES = 11;
   localparam int PHASE_TICKS = 150;
   localparam int MAX_RUN = 300;
   localparam int SAT_HOLD = 120;
   localparam int SAT_RELEASE = 30;
   localparam int WATCHDOG_LIMIT = 1000;

   typedef enum logic {ROW_TICK, ROW_CSR} plan_kind_type;

   typedef struct packed {
      plan_kind_type            kind;
      logic                     next_lvl;
      logic                     select_lvl;
      logic [7:0]               count;
      logic                     typed;
      bslp_result_type          want;
      logic [CSR_IDX_W-1:0]     reg_idx;
      logic [CSR_DATA_W-1:0]    reg_data;
   } plan_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_next_level = 1'b1;
   logic                  req_select_level = 1'b1;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_next_short;
   logic                  rsp_next_long;
   logic                  rsp_select_short;
   logic                  rsp_select_long;
   logic                  rsp_next_active;
   logic                  rsp_select_active;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // button model state
   logic [PERIOD_W-1:0] model_period = SAMPLE_PERIOD_RESET;
   logic [HOLD_W-1:0]   model_long = LONG_PRESS_RESET;
   logic [PERIOD_W-1:0] model_countdown = SAMPLE_PERIOD_RESET;
   logic                model_held [2] = '{1'b0, 1'b0};
   logic                model_repeat [2] = '{1'b0, 1'b0};
   logic [HOLD_W-1:0]   model_timer [2] = '{16'd0, 16'd0};

   bslp_result_type report_queue [$];
   plan_row_type    plan [$];
   bslp_result_type rsp_got;
   bslp_result_type rsp_want;

   int  mismatches = 0;
   int  ticks_sent = 0;
   int  reg_writes = 0;
   int  short_events = 0;
   int  long_events = 0;
   int  quiet_cycles = 0;
   int  stall_left = 0;
   bit  gap_on = 1'b1;
   bit  stall_on = 1'b1;

   button_short_long_press_detector i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_next_level    (req_next_level),
      .req_select_level  (req_select_level),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_next_short    (rsp_next_short),
      .rsp_next_long     (rsp_next_long),
      .rsp_select_short  (rsp_select_short),
      .rsp_select_long   (rsp_select_long),
      .rsp_next_active   (rsp_next_active),
      .rsp_select_active (rsp_select_active),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bslp_result_type button_model_tick(input logic next_lvl,
                                                         input logic select_lvl);
      logic            pressed [2];
      logic            ev_short [2];
      logic            ev_long [2];
      bslp_result_type r;
      pressed[0] = !next_lvl;
      pressed[1] = !select_lvl;
      for (int b = 0; b < 2; b++) begin
         ev_short[b] = 1'b0;
         ev_long[b] = 1'b0;
         if (model_held[b] && model_timer[b] != HOLD_MAX)
            model_timer[b] = model_timer[b] + 1'b1;
      end
      if (model_countdown <= 1) begin
         model_countdown = model_period;
         for (int b = 0; b < 2; b++) begin
            if (pressed[b]) begin
               if (model_held[b]) begin
                  if (model_timer[b] > model_long) begin
                     ev_long[b] = 1'b1;
                     model_repeat[b] = 1'b1;
                     model_timer[b] = '0;
                  end
               end else begin
                  model_held[b] = 1'b1;
                  model_timer[b] = '0;
               end
            end else if (model_held[b]) begin
               if (model_repeat[b])
                  model_repeat[b] = 1'b0;
               else
                  ev_short[b] = 1'b1;
               model_held[b] = 1'b0;
               model_timer[b] = '0;
            end
         end
      end else begin
         model_countdown = model_countdown - 1'b1;
      end
      r.next_ev.short_ev = ev_short[0];
      r.next_ev.long_ev = ev_long[0];
      r.select_ev.short_ev = ev_short[1];
      r.select_ev.long_ev = ev_long[1];
      r.next_active = pressed[0];
      r.select_active = pressed[1];
      return r;
   endfunction

   function automatic bslp_result_type levels_only(input logic next_on, input logic select_on);
      bslp_result_type r;
      r = '0;
      r.next_active = next_on;
      r.select_active = select_on;
      return r;
   endfunction

   function automatic void add_tick(input logic next_lvl, input logic select_lvl,
                                    input int count, input logic typed,
                                    input bslp_result_type want);
      plan_row_type row;
      row = '0;
      row.kind = ROW_TICK;
      row.next_lvl = next_lvl;
      row.select_lvl = select_lvl;
      row.count = 8'(count);
      row.typed = typed;
      row.want = want;
      plan.push_back(row);
   endfunction

   function automatic void add_write(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] val);
      plan_row_type row;
      row = '0;
      row.kind = ROW_CSR;
      row.reg_idx = idx;
      row.reg_data = val;
      plan.push_back(row);
   endfunction

   function automatic void check_field(input string what, input logic want_bit,
                                       input logic got_bit);
      if (got_bit !== want_bit) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %b, actual %b", $time, what, want_bit, got_bit);
      end
   endfunction

   task automatic send_tick(input logic next_lvl, input logic select_lvl,
                            input logic typed, input bslp_result_type typed_want);
      bslp_result_type predicted;
      req_valid <= 1'b1;
      req_next_level <= next_lvl;
      req_select_level <= select_lvl;
      do @(posedge clock); while (req_stall !== 1'b0);
      predicted = button_model_tick(next_lvl, select_lvl);
      report_queue.push_back(typed ? typed_want : predicted);
      ticks_sent++;
      short_events += predicted.next_ev.short_ev + predicted.select_ev.short_ev;
      long_events += predicted.next_ev.long_ev + predicted.select_ev.long_ev;
      if (gap_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (report_queue.size() != 0);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      drain_results();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      if (idx == CSR_SAMPLE_PERIOD)
         model_period = val[PERIOD_W-1:0];
      else if (idx == CSR_LONG_PRESS)
         model_long = val[HOLD_W-1:0];
      reg_writes++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_got = {rsp_next_short, rsp_next_long, rsp_select_short, rsp_select_long,
                       rsp_next_active, rsp_select_active};
            if (report_queue.size() == 0) begin
               mismatches++;
               $display("%0t: result beat with nothing expected, actual %b", $time, rsp_got);
            end else begin
               rsp_want = report_queue.pop_front();
               check_field("next_short", rsp_want.next_ev.short_ev, rsp_got.next_ev.short_ev);
               check_field("next_long", rsp_want.next_ev.long_ev, rsp_got.next_ev.long_ev);
               check_field("select_short", rsp_want.select_ev.short_ev,
                           rsp_got.select_ev.short_ev);
               check_field("select_long", rsp_want.select_ev.long_ev,
                           rsp_got.select_ev.long_ev);
               check_field("next_active", rsp_want.next_active, rsp_got.next_active);
               check_field("select_active", rsp_want.select_active, rsp_got.select_active);
            end
         end
         if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if (stall_on && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            stall_left = $urandom_range(0, 5);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      int                  phase;
      int                  n;
      int                  pick;
      int                  unit;
      int                  run_left [2];
      logic                lvl [2];
      logic [PERIOD_W-1:0] period;
      logic [HOLD_W-1:0]   lp;
      logic [CSR_DATA_W-1:0] cdata;

      run_left[0] = 0;
      run_left[1] = 0;
      lvl[0] = 1'b1;
      lvl[1] = 1'b1;

      add_tick(1'b1, 1'b1, 1, 1'b1, levels_only(1'b0, 1'b0));
      add_tick(1'b0, 1'b1, 1, 1'b1, levels_only(1'b1, 1'b0));
      add_tick(1'b1, 1'b0, 1, 1'b1, levels_only(1'b0, 1'b1));
      add_tick(1'b0, 1'b0, 1, 1'b1, levels_only(1'b1, 1'b1));
      add_write(CSR_SAMPLE_PERIOD, 16'd1);
      add_write(CSR_LONG_PRESS, 16'd1);
      // run the reset countdown out; nothing is held
      add_tick(1'b1, 1'b1, 46, 1'b1, levels_only(1'b0, 1'b0));
      add_tick(1'b0, 1'b1, 4, 1'b0, '0);
      add_tick(1'b0, 1'b0, 1, 1'b0, '0);
      add_tick(1'b1, 1'b0, 1, 1'b0, '0);
      add_tick(1'b1, 1'b1, 1, 1'b0, '0);
      add_tick(1'b0, 1'b0, 1, 1'b0, '0);
      add_tick(1'b1, 1'b1, 1, 1'b0, '0);
      add_write(CSR_SAMPLE_PERIOD, 16'd0);
      add_tick(1'b0, 1'b1, 3, 1'b0, '0);
      add_tick(1'b1, 1'b1, 1, 1'b0, '0);
      add_write(CSR_LONG_PRESS, 16'd65534);
      add_write(CSR_SAMPLE_PERIOD, 16'hFFFF);
      add_write(CSR_SPARE_A, 16'h1234);
      add_write(CSR_SPARE_B, 16'hEDCB);
      add_tick(1'b0, 1'b1, 2, 1'b0, '0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR)
            write_reg(plan[i].reg_idx, plan[i].reg_data);
         else
            repeat (plan[i].count)
               send_tick(plan[i].next_lvl, plan[i].select_lvl, plan[i].typed, plan[i].want);
      end

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         gap_on = ($urandom_range(0, 3) != 0);
         stall_on = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 5))
            0: period = 10'd1023;
            1: period = PERIOD_W'($urandom_range(0, 1));
            default: period = PERIOD_W'($urandom_range(1, 8));
         endcase
         case ($urandom_range(0, 5))
            0: lp = 16'd65534;
            1: lp = 16'd1;
            default: lp = HOLD_W'($urandom_range(2, 40));
         endcase
         pick = $urandom_range(0, 3);
         if (pick != 1) begin
            cdata = CSR_DATA_W'($urandom);
            cdata[PERIOD_W-1:0] = period;
            write_reg(CSR_SAMPLE_PERIOD, cdata);
         end
         if (pick != 2)
            write_reg(CSR_LONG_PRESS, lp);
         if (pick == 0) begin
            cdata = CSR_DATA_W'($urandom);
            write_reg($urandom_range(0, 1) ? CSR_SPARE_A : CSR_SPARE_B, cdata);
         end
         unit = (model_period < 2) ? 1 : int'(model_period);
         for (n = 0; n < PHASE_TICKS; n++) begin
            for (int b = 0; b < 2; b++) begin
               if (run_left[b] == 0) begin
                  lvl[b] = ~lvl[b];
                  pick = $urandom_range(0, 9);
                  if (pick < 2)
                     run_left[b] = $urandom_range(1, 2);
                  else if (!lvl[b] && pick < 6)
                     run_left[b] = model_long * $urandom_range(1, 3) + $urandom_range(1, 2 * unit);
                  else
                     run_left[b] = $urandom_range(1, 3 * unit);
                  if (run_left[b] > MAX_RUN)
                     run_left[b] = $urandom_range(MAX_RUN / 2, MAX_RUN);
               end
               run_left[b]--;
            end
            send_tick(lvl[0], lvl[1], 1'b0, '0);
            // hold off until every report is back
            if ($urandom_range(0, 59) == 0)
               drain_results();
         end
      end

      // hold both buttons against the top long press time, then release
      gap_on = 1'b0;
      stall_on = 1'b0;
      write_reg(CSR_LONG_PRESS, HOLD_MAX);
      write_reg(CSR_SAMPLE_PERIOD, 16'd1);
      repeat (SAT_HOLD) send_tick(1'b0, 1'b0, 1'b0, '0);
      repeat (SAT_RELEASE) send_tick(1'b1, 1'b1, 1'b0, '0);

      drain_results();
      repeat (8) @(posedge clock);

      $display("Covered %0d tick beats and %0d register writes, with sampling on every tick,",
               ticks_sent, reg_writes);
      $display("masked and spare writes, and a hold at the top long press time: %0d short, %0d long.",
               short_events, long_events);
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
